// ----- rtl/tmd_pkg.sv -----
// Shared constants and types for the trimmed mean / max deviation unit.
// No dependencies; imported by every module of the block.
package tmd_pkg;

  localparam int MAX_SAMPLES  = 512;
  localparam int SAMPLE_W     = 24;
  localparam int COUNT_W      = 10;
  localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
  localparam int SAMPLE_LIMIT = (MAX_SAMPLES < COUNT_MAX) ? MAX_SAMPLES : COUNT_MAX;
  localparam int MIN_COUNT    = 3;

  // sum of SAMPLE_LIMIT samples, each below 2**SAMPLE_W
  localparam int SUM_W  = $clog2(SAMPLE_LIMIT) + SAMPLE_W;
  localparam int PROD_W = SAMPLE_W + COUNT_W;
  // rounding numerator 2*n + k
  localparam int NUM_W  = PROD_W + 2;
  // rounding divisor 2*k
  localparam int DEN_W  = COUNT_W + 1;
  localparam int REM_W  = NUM_W - SAMPLE_W;
  localparam int STEP_W = $clog2(SAMPLE_W);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_LONG  = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0] second_largest;
    logic [SAMPLE_W-1:0] smallest;
    logic [SAMPLE_W-1:0] second_smallest;
    logic                too_long;
  } tmd_stats_t;

endpackage

// ----- rtl/trimmed_mean_with_max_deviation_unit.sv -----
// Top level of the trimmed mean / max deviation unit: sequencer and datapath.
// Depends on tmd_pkg, tmd_tracker and tmd_divider.
//
// Usage:
//   Samples (unsigned Q16.8) enter on sample/last_sample; a transfer happens
//   at a rising edge with start high and busy low. Samples that are not the
//   last of a batch are taken one per cycle and busy stays low.
//   The transfer of the last sample starts the batch finish: busy rises and
//   stays high until the result is out. The finish drops one largest and one
//   smallest sample, divides the rest by count-2 with round-to-nearest
//   (ties up), and finds the largest gap of the kept samples from the mean.
//   A short or too-long batch ends at the status check (status 1 or 2,
//   both value fields zero); any other batch runs five setup steps that
//   share one 24x10 multiplier, then two 24-step passes of the
//   one-bit-per-cycle divider.
//   The result is valid on trimmed_mean, max_deviation and status while
//   done is high, for exactly one cycle; the receiver cannot stall it. Busy
//   is already low in the strobe cycle and the next batch may begin.
//   Reset (rst, synchronous) clears the batch statistics, idles the
//   sequencer and drops any finish in progress without a result.
module trimmed_mean_with_max_deviation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tmd_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last_sample,
  output logic                         done,
  output logic [tmd_pkg::SAMPLE_W-1:0] trimmed_mean,
  output logic [tmd_pkg::SAMPLE_W-1:0] max_deviation,
  output logic [1:0]                   status
);
  import tmd_pkg::*;

  localparam logic [2:0] S_ACC  = 3'd0;  // taking samples
  localparam logic [2:0] S_EVAL = 3'd1;  // status check, sum minus largest
  localparam logic [2:0] S_KEPT = 3'd2;  // minus smallest
  localparam logic [2:0] S_MHI  = 3'd3;  // second_largest * k
  localparam logic [2:0] S_MLO  = 3'd4;  // upward gap, second_smallest * k
  localparam logic [2:0] S_DOWN = 3'd5;  // downward gap, start mean divide
  localparam logic [2:0] S_DIVM = 3'd6;  // mean divide running
  localparam logic [2:0] S_DIVD = 3'd7;  // deviation divide running

  logic [2:0]          state;
  tmd_stats_t          stats;
  logic                accept;
  logic                clear;

  logic [COUNT_W-1:0]  k;
  logic [SUM_W-1:0]    kept;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   up;
  logic [PROD_W-1:0]   down;
  logic [NUM_W-1:0]    dev_num;

  logic [SAMPLE_W-1:0] mul_a;
  logic [PROD_W-1:0]   mul_out;
  logic [PROD_W-1:0]   kept_ext;
  logic [PROD_W-1:0]   gap_max;
  logic [NUM_W-1:0]    mean_num;

  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_q;

  assign busy   = state != S_ACC;
  assign accept = start && !busy;

  // batch closes once the result is committed
  assign clear = (state == S_EVAL && (stats.too_long || stats.count < COUNT_W'(MIN_COUNT)))
              || (state == S_DIVD && div_done);

  tmd_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .accept (accept),
    .sample (sample),
    .stats  (stats)
  );

  // shared multiplier, used for the high and the low bound in turn
  assign mul_a    = (state == S_MHI) ? stats.second_largest : stats.second_smallest;
  assign mul_out  = PROD_W'(mul_a) * PROD_W'(k);
  assign kept_ext = PROD_W'(kept);
  assign gap_max  = (up > down) ? up : down;
  // round to nearest: (2n + k) / 2k
  assign mean_num = NUM_W'({kept, 1'b0}) + NUM_W'(k);

  assign div_start = (state == S_DOWN) || (state == S_DIVM && div_done);
  assign div_num   = (state == S_DOWN) ? mean_num : dev_num;

  tmd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      ({k, 1'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_ACC: begin
          if (accept && last_sample) state <= S_EVAL;
        end
        S_EVAL: begin
          if (stats.too_long || stats.count < COUNT_W'(MIN_COUNT)) begin
            done  <= 1'b1;
            state <= S_ACC;
          end else begin
            state <= S_KEPT;
          end
        end
        S_KEPT: state <= S_MHI;
        S_MHI:  state <= S_MLO;
        S_MLO:  state <= S_DOWN;
        S_DOWN: state <= S_DIVM;
        S_DIVM: begin
          if (div_done) state <= S_DIVD;
        end
        S_DIVD: begin
          if (div_done) begin
            done  <= 1'b1;
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_EVAL: begin
        k    <= stats.count - COUNT_W'(2);
        kept <= stats.sum - SUM_W'(stats.largest);
        if (stats.too_long) begin
          status        <= ST_LONG;
          trimmed_mean  <= '0;
          max_deviation <= '0;
        end else if (stats.count < COUNT_W'(MIN_COUNT)) begin
          status        <= ST_SHORT;
          trimmed_mean  <= '0;
          max_deviation <= '0;
        end
      end
      S_KEPT: kept <= kept - SUM_W'(stats.smallest);
      S_MHI:  prod <= mul_out;
      S_MLO: begin
        up   <= (prod > kept_ext) ? (prod - kept_ext) : '0;
        prod <= mul_out;
      end
      S_DOWN: down <= (kept_ext > prod) ? (kept_ext - prod) : '0;
      S_DIVM: begin
        dev_num <= NUM_W'({gap_max, 1'b0}) + NUM_W'(k);
        if (div_done) trimmed_mean <= div_q;
      end
      S_DIVD: begin
        if (div_done) begin
          max_deviation <= div_q;
          status        <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // a last-sample transfer always starts a finish
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && last_sample |=> busy)
    else $error("busy did not rise after last sample");

  // strobe is a single cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // a result only comes out of a finish
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result without a finish in progress");

  // error results carry zero fields
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> trimmed_mean == '0 && max_deviation == '0)
    else $error("nonzero fields on error status");

  // divider is only started while idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !u_divider.active)
    else $error("divider restarted while running");
`endif

endmodule

// ----- rtl/tmd_tracker.sv -----
// Batch statistics: count, running sum, two largest and two smallest samples.
// Depends on tmd_pkg.
module tmd_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         accept,
  input  logic [tmd_pkg::SAMPLE_W-1:0] sample,
  output tmd_pkg::tmd_stats_t          stats
);
  import tmd_pkg::*;

  tmd_stats_t stats_next;

  always_comb begin
    stats_next = stats;
    if (accept && !stats.too_long) begin
      if (stats.count >= COUNT_W'(SAMPLE_LIMIT)) begin
        stats_next.too_long = 1'b1;
      end else begin
        stats_next.count = stats.count + 1'b1;
        stats_next.sum   = stats.sum + SUM_W'(sample);
        if (sample > stats.largest) begin
          stats_next.second_largest = stats.largest;
          stats_next.largest        = sample;
        end else if (sample > stats.second_largest) begin
          stats_next.second_largest = sample;
        end
        if (sample < stats.smallest) begin
          stats_next.second_smallest = stats.smallest;
          stats_next.smallest        = sample;
        end else if (sample < stats.second_smallest) begin
          stats_next.second_smallest = sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      stats.count           <= '0;
      stats.sum             <= '0;
      stats.largest         <= '0;
      stats.second_largest  <= '0;
      stats.smallest        <= '1;
      stats.second_smallest <= '1;
      stats.too_long        <= 1'b0;
    end else begin
      stats <= stats_next;
    end
  end

endmodule

// ----- rtl/tmd_divider.sv -----
// Restoring divider, one quotient bit per cycle, SAMPLE_W-bit quotient.
// Depends on tmd_pkg. Caller guarantees num < den * 2**SAMPLE_W.
module tmd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tmd_pkg::NUM_W-1:0]    num,
  input  logic [tmd_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [tmd_pkg::SAMPLE_W-1:0] quotient
);
  import tmd_pkg::*;

  logic              active;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // remainder stays below divisor, so its top bit is always zero
  assign trial = {rem[REM_W-2:0], quotient[SAMPLE_W-1]};
  assign fits  = trial >= REM_W'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SAMPLE_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in as the low numerator bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num[NUM_W-1:SAMPLE_W];
      quotient <= num[SAMPLE_W-1:0];
      divisor  <= den;
    end else if (active) begin
      rem      <= fits ? (trial - REM_W'(divisor)) : trial;
      quotient <= {quotient[SAMPLE_W-2:0], fits};
    end
  end

endmodule
